// ----- sv/tfpd_pkg.sv -----
package tfpd_pkg;

  localparam int RUN_COUNT_WIDTH = 16;
  localparam int SAMPLE_WIDTH    = 10;
  localparam int GAIN_WIDTH      = 10;
  localparam int CORR_WIDTH      = 15;
  localparam int ERR_WIDTH       = 3;
  localparam int DIFF_MAG_WIDTH  = 3;
  localparam int NUM_WIDTH       = GAIN_WIDTH + DIFF_MAG_WIDTH;
  localparam int DEN_WIDTH       = RUN_COUNT_WIDTH + 1;
  localparam int CNT_WIDTH       = $clog2(NUM_WIDTH);
  localparam int P_WIDTH         = GAIN_WIDTH + ERR_WIDTH + 1;

  localparam logic signed [ERR_WIDTH-1:0] ERR_ZERO = 3'sd0;
  localparam logic signed [ERR_WIDTH-1:0] ERR_POS1 = 3'sd1;
  localparam logic signed [ERR_WIDTH-1:0] ERR_NEG1 = -3'sd1;
  localparam logic signed [ERR_WIDTH-1:0] ERR_POS3 = 3'sd3;
  localparam logic signed [ERR_WIDTH-1:0] ERR_NEG3 = -3'sd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

// ----- sv/tfpd_in_if.sv -----
interface tfpd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [tfpd_pkg::SAMPLE_WIDTH-1:0]    left_sample;
  logic [tfpd_pkg::SAMPLE_WIDTH-1:0]    right_sample;
  logic [tfpd_pkg::SAMPLE_WIDTH-1:0]    threshold_knob;
  logic [tfpd_pkg::GAIN_WIDTH-1:0]      gain_p;
  logic [tfpd_pkg::GAIN_WIDTH-1:0]      gain_d;

  modport source (
    output valid, left_sample, right_sample, threshold_knob, gain_p, gain_d,
    input  ready
  );
  modport sink (
    input  valid, left_sample, right_sample, threshold_knob, gain_p, gain_d,
    output ready
  );
endinterface

// ----- sv/tfpd_out_if.sv -----
interface tfpd_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [tfpd_pkg::CORR_WIDTH-1:0]  drive_correction;
  logic signed [tfpd_pkg::ERR_WIDTH-1:0]   position_error;

  modport source (
    output valid, drive_correction, position_error,
    input  ready
  );
  modport sink (
    input  valid, drive_correction, position_error,
    output ready
  );
endinterface

// ----- sv/tfpd_div.sv -----
module tfpd_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tfpd_pkg::NUM_WIDTH-1:0] num,
  input  logic [tfpd_pkg::DEN_WIDTH-1:0] den,
  output logic [tfpd_pkg::NUM_WIDTH-1:0] quo,
  output logic                           done
);

  logic                             busy;
  logic [tfpd_pkg::CNT_WIDTH-1:0]   cnt;
  logic [tfpd_pkg::DEN_WIDTH-1:0]   divisor;
  logic [tfpd_pkg::DEN_WIDTH-1:0]   rem;
  logic [tfpd_pkg::DEN_WIDTH-1:0]   rem_next;
  logic [tfpd_pkg::NUM_WIDTH-1:0]   work;
  logic [tfpd_pkg::DEN_WIDTH:0]     rem_shift;
  logic [tfpd_pkg::DEN_WIDTH:0]     rem_sub;
  logic                             fits;

  // one restoring step per cycle
  always_comb begin
    rem_shift = {rem, work[tfpd_pkg::NUM_WIDTH-1]};
    rem_sub   = rem_shift - {1'b0, divisor};
    fits      = rem_shift >= {1'b0, divisor};
    rem_next  = fits ? rem_sub[tfpd_pkg::DEN_WIDTH-1:0]
                     : rem_shift[tfpd_pkg::DEN_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= tfpd_pkg::CNT_WIDTH'(tfpd_pkg::NUM_WIDTH - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      work    <= num;
      divisor <= den;
    end else if (busy) begin
      rem  <= rem_next;
      work <= {work[tfpd_pkg::NUM_WIDTH-2:0], fits};
    end
  end

  assign quo = work;

endmodule

// ----- sv/tape_follow_pd_error_core.sv -----
// channel  | dir | payload
// ---------+-----+--------------------------------------------------------------
// sensor   | in  | left_sample, right_sample, threshold_knob, gain_p, gain_d
// result   | out | drive_correction, position_error
//
// one transaction at a time: the accept in the idle step, the serial
// divider (one quotient bit per cycle), the done flag, then the finish step
// that forms the sum. sensor.ready is high only in the idle step.
// the result sits in an output register; a stalled result holds the current
// item in the finish step until the register frees.
// rst is synchronous; it clears the error history and both run counters.
module tape_follow_pd_error_core (
  input  logic        clk,
  input  logic        rst,
  tfpd_in_if.sink     sensor,
  tfpd_out_if.source  result
);

  tfpd_pkg::state_t state, state_next;

  logic signed [tfpd_pkg::ERR_WIDTH-1:0]   prev_error;
  logic signed [tfpd_pkg::ERR_WIDTH-1:0]   prev_nonzero_error;
  logic [tfpd_pkg::RUN_COUNT_WIDTH-1:0]    prior_run;
  logic [tfpd_pkg::RUN_COUNT_WIDTH-1:0]    current_run;
  logic [tfpd_pkg::RUN_COUNT_WIDTH-1:0]    prior_run_next;
  logic [tfpd_pkg::RUN_COUNT_WIDTH-1:0]    run_base;
  logic [tfpd_pkg::RUN_COUNT_WIDTH-1:0]    current_run_next;

  logic [tfpd_pkg::SAMPLE_WIDTH-1:0]       thr;
  logic                                    left_on;
  logic                                    right_on;
  logic signed [tfpd_pkg::ERR_WIDTH-1:0]   err_new;
  logic signed [tfpd_pkg::ERR_WIDTH:0]     diff;
  logic [tfpd_pkg::ERR_WIDTH:0]            diff_neg;
  logic [tfpd_pkg::DIFF_MAG_WIDTH-1:0]     diff_mag;
  logic [tfpd_pkg::NUM_WIDTH-1:0]          num;
  logic [tfpd_pkg::DEN_WIDTH-1:0]          den;
  logic signed [tfpd_pkg::P_WIDTH-1:0]     kp_ext;
  logic signed [tfpd_pkg::P_WIDTH-1:0]     err_ext;
  logic signed [tfpd_pkg::P_WIDTH-1:0]     p_val;

  logic signed [tfpd_pkg::P_WIDTH-1:0]     p_reg;
  logic                                    neg_reg;
  logic signed [tfpd_pkg::ERR_WIDTH-1:0]   err_reg;

  logic [tfpd_pkg::NUM_WIDTH-1:0]          quo;
  logic                                    div_done;
  logic [tfpd_pkg::CORR_WIDTH-1:0]         d_mag;
  logic signed [tfpd_pkg::CORR_WIDTH-1:0]  d_val;
  logic signed [tfpd_pkg::CORR_WIDTH-1:0]  sum;

  logic                                    out_valid;
  logic signed [tfpd_pkg::CORR_WIDTH-1:0]  out_corr;
  logic signed [tfpd_pkg::ERR_WIDTH-1:0]   out_err;

  logic accept;
  logic out_free;

  assign accept   = sensor.valid && sensor.ready;
  assign out_free = !out_valid || result.ready;

  // classification
  always_comb begin
    thr      = sensor.threshold_knob >> 2;
    left_on  = sensor.left_sample >= thr;
    right_on = sensor.right_sample >= thr;
    case ({left_on, right_on})
      2'b11: err_new = tfpd_pkg::ERR_ZERO;
      2'b01: err_new = tfpd_pkg::ERR_NEG1;
      2'b10: err_new = tfpd_pkg::ERR_POS1;
      default: begin
        if (prev_error < 0) err_new = tfpd_pkg::ERR_NEG3;
        else if (prev_error > 0) err_new = tfpd_pkg::ERR_POS3;
        else if (prev_nonzero_error < 0) err_new = tfpd_pkg::ERR_POS1;
        else if (prev_nonzero_error > 0) err_new = tfpd_pkg::ERR_NEG1;
        else err_new = tfpd_pkg::ERR_ZERO;
      end
    endcase
  end

  // run counters
  always_comb begin
    if (err_new != prev_error) begin
      prior_run_next = current_run;
      run_base       = '0;
    end else begin
      prior_run_next = prior_run;
      run_base       = current_run;
    end
    current_run_next = (&run_base) ? run_base : run_base + 1'b1;
    den = {1'b0, prior_run_next} + {1'b0, current_run_next};
  end

  // numerator magnitude and proportional term
  always_comb begin
    diff     = {err_new[tfpd_pkg::ERR_WIDTH-1], err_new}
             - {prev_error[tfpd_pkg::ERR_WIDTH-1], prev_error};
    diff_neg = -diff;
    diff_mag = diff[tfpd_pkg::ERR_WIDTH] ? diff_neg[tfpd_pkg::DIFF_MAG_WIDTH-1:0]
                                         : diff[tfpd_pkg::DIFF_MAG_WIDTH-1:0];
    num      = tfpd_pkg::NUM_WIDTH'(sensor.gain_d) * tfpd_pkg::NUM_WIDTH'(diff_mag);
    kp_ext   = {{(tfpd_pkg::P_WIDTH - tfpd_pkg::GAIN_WIDTH){1'b0}}, sensor.gain_p};
    err_ext  = {{(tfpd_pkg::P_WIDTH - tfpd_pkg::ERR_WIDTH){err_new[tfpd_pkg::ERR_WIDTH-1]}},
                err_new};
    p_val    = kp_ext * err_ext;
  end

  tfpd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .num   (num),
    .den   (den),
    .quo   (quo),
    .done  (div_done)
  );

  always_comb begin
    d_mag = {{(tfpd_pkg::CORR_WIDTH - tfpd_pkg::NUM_WIDTH){1'b0}}, quo};
    d_val = neg_reg ? -$signed(d_mag) : $signed(d_mag);
    sum   = {{(tfpd_pkg::CORR_WIDTH - tfpd_pkg::P_WIDTH){p_reg[tfpd_pkg::P_WIDTH-1]}}, p_reg}
          + d_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tfpd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sensor.ready = 1'b0;
    case (state)
      tfpd_pkg::ST_IDLE: begin
        sensor.ready = 1'b1;
        if (sensor.valid) state_next = tfpd_pkg::ST_DIVIDE;
      end
      tfpd_pkg::ST_DIVIDE: begin
        if (div_done) state_next = tfpd_pkg::ST_FINISH;
      end
      tfpd_pkg::ST_FINISH: begin
        if (out_free) state_next = tfpd_pkg::ST_IDLE;
      end
      default: state_next = tfpd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error         <= tfpd_pkg::ERR_ZERO;
      prev_nonzero_error <= tfpd_pkg::ERR_ZERO;
      prior_run          <= '0;
      current_run        <= '0;
    end else if (accept) begin
      prev_error  <= err_new;
      prior_run   <= prior_run_next;
      current_run <= current_run_next;
      if (err_new != tfpd_pkg::ERR_ZERO) prev_nonzero_error <= err_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_reg   <= p_val;
      neg_reg <= diff[tfpd_pkg::ERR_WIDTH];
      err_reg <= err_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tfpd_pkg::ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tfpd_pkg::ST_FINISH && out_free) begin
      out_corr <= sum;
      out_err  <= err_reg;
    end
  end

  assign result.valid            = out_valid;
  assign result.drive_correction = out_corr;
  assign result.position_error   = out_err;

  a_accept_starts_divide: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == tfpd_pkg::ST_DIVIDE)
    else $error("divide did not start after accept");

  a_done_only_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == tfpd_pkg::ST_DIVIDE)
    else $error("divider finished outside the divide step");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    accept |=> current_run != '0)
    else $error("current run is zero after a transaction");

  a_finish_loads_output: assert property (@(posedge clk) disable iff (rst)
    state == tfpd_pkg::ST_FINISH && out_free |=> out_valid)
    else $error("finished result not presented");

endmodule
